FILE: sv/cse_pkg.sv
// Shared types and constants for the color sort eject pulser.
// Holds register indexes, reset values, drive codes and stage structs.
// No dependencies.
`default_nettype none

package cse_pkg;

	// Configuration port widths
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	// Register indexes
	localparam logic [CfgIdxW-1:0] CFG_TARGET_IS_BLUE = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_PROX_THRESHOLD = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_RED_HUE_HIGH   = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_BLUE_HUE_LOW   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_BLUE_HUE_HIGH  = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_RUN_MS         = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_REVERSE_END_MS = 3'd6;

	// Register reset values
	localparam logic [7:0]  PROX_THRESHOLD_RST = 8'd150;
	localparam logic [8:0]  RED_HUE_HIGH_RST   = 9'd25;
	localparam logic [8:0]  BLUE_HUE_LOW_RST   = 9'd150;
	localparam logic [8:0]  BLUE_HUE_HIGH_RST  = 9'd230;
	localparam logic [15:0] RUN_MS_RST         = 16'd175;
	localparam logic [15:0] REVERSE_END_MS_RST = 16'd225;

	// Drive and indicator codes
	localparam logic signed [7:0] DRIVE_FWD  = 8'sd127;
	localparam logic signed [7:0] DRIVE_REV  = -8'sd50;
	localparam logic signed [7:0] DRIVE_NONE = 8'sd0;
	localparam logic [6:0] LED_ON  = 7'd100;
	localparam logic [6:0] LED_OFF = 7'd0;
	localparam logic [1:0] RUMBLE_NONE   = 2'd0;
	localparam logic [1:0] RUMBLE_SINGLE = 2'd1;
	localparam logic [1:0] RUMBLE_DOUBLE = 2'd2;

	typedef struct packed {
		logic        target_is_blue;
		logic [7:0]  proximity_threshold;
		logic [8:0]  red_hue_high;
		logic [8:0]  blue_hue_low;
		logic [8:0]  blue_hue_high;
		logic [15:0] run_ms;
		logic [15:0] reverse_end_ms;
	} cfg_t;

	typedef struct packed {
		logic        button_level;
		logic [7:0]  proximity;
		logic [8:0]  hue_degrees;
		logic [31:0] now_ms;
	} item_t;

	typedef struct packed {
		logic              drive_issued;
		logic signed [7:0] conveyor_drive;
		logic [6:0]        led_level;
		logic [1:0]        rumble_request;
		logic              detection_on;
		logic              target_seen;
	} result_t;

endpackage

`default_nettype wire

FILE: sv/color_sort_eject_pulser_core.sv
// Top level of the color sort eject pulser: input register, step logic,
// result register and configuration registers.
// Depends on cse_pkg, cse_cfg and cse_step.
//
// Channel  Direction  Handshake              Payload
// in       sink       in_valid / in_stall    button_level, proximity, hue_degrees, now_ms
// out      source     out_valid / out_stall  drive_issued, conveyor_drive, led_level,
//                                            rumble_request, detection_on, target_seen
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per clock sustained while out_stall is low; an item passes from the
// input register through the step logic into the result register, which
// drives the outputs until the result is taken.
// Reset clears the pulse and toggle state, enables detection and loads the
// register defaults. A stalled output holds its result; the input register
// keeps taking items until it too is full. cfg_ready is always high.
`default_nettype none

module color_sort_eject_pulser_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output      logic                         in_stall,
	input  wire logic                         button_level,
	input  wire logic [7:0]                   proximity,
	input  wire logic [8:0]                   hue_degrees,
	input  wire logic [31:0]                  now_ms,
	output      logic                         out_valid,
	input  wire logic                         out_stall,
	output      logic                         drive_issued,
	output      logic signed [7:0]            conveyor_drive,
	output      logic [6:0]                   led_level,
	output      logic [1:0]                   rumble_request,
	output      logic                         detection_on,
	output      logic                         target_seen,
	input  wire logic                         cfg_valid,
	output      logic                         cfg_ready,
	input  wire logic [cse_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [cse_pkg::CfgDataW-1:0] cfg_data
);
	import cse_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t result;
	result_t result_s2;
	logic    valid_s2;
	logic    advance;
	logic    in_take;

	assign cfg_ready = 1'b1;

	cse_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Move an item into the result register when there is room
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;
	assign in_take  = in_valid & ~in_stall;

	cse_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.cfg    (cfg),
		.item   (item_s1),
		.result (result)
	);

	// Hold the incoming item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take || advance) begin
			valid_s1 <= in_take;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.button_level <= button_level;
			item_s1.proximity    <= proximity;
			item_s1.hue_degrees  <= hue_degrees;
			item_s1.now_ms       <= now_ms;
		end
	end

	// Hold the finished result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign out_valid      = valid_s2;
	assign drive_issued   = result_s2.drive_issued;
	assign conveyor_drive = result_s2.conveyor_drive;
	assign led_level      = result_s2.led_level;
	assign rumble_request = result_s2.rumble_request;
	assign detection_on   = result_s2.detection_on;
	assign target_seen    = result_s2.target_seen;

endmodule

`default_nettype wire

FILE: sv/cse_cfg.sv
// Configuration register file for the color sort eject pulser.
// Depends on cse_pkg for register indexes, reset values and cfg_t.
`default_nettype none

module cse_cfg (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            wr_en,
	input  wire logic [cse_pkg::CfgIdxW-1:0]     wr_index,
	input  wire logic [cse_pkg::CfgDataW-1:0]    wr_data,
	output cse_pkg::cfg_t                        cfg
);
	import cse_pkg::*;

	cfg_t cfg_q;

	// Decode the index and store the low bits; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_is_blue      <= 1'b0;
			cfg_q.proximity_threshold <= PROX_THRESHOLD_RST;
			cfg_q.red_hue_high        <= RED_HUE_HIGH_RST;
			cfg_q.blue_hue_low        <= BLUE_HUE_LOW_RST;
			cfg_q.blue_hue_high       <= BLUE_HUE_HIGH_RST;
			cfg_q.run_ms              <= RUN_MS_RST;
			cfg_q.reverse_end_ms      <= REVERSE_END_MS_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_TARGET_IS_BLUE: cfg_q.target_is_blue      <= wr_data[0];
				CFG_PROX_THRESHOLD: cfg_q.proximity_threshold <= wr_data[7:0];
				CFG_RED_HUE_HIGH:   cfg_q.red_hue_high        <= wr_data[8:0];
				CFG_BLUE_HUE_LOW:   cfg_q.blue_hue_low        <= wr_data[8:0];
				CFG_BLUE_HUE_HIGH:  cfg_q.blue_hue_high       <= wr_data[8:0];
				CFG_RUN_MS:         cfg_q.run_ms              <= wr_data;
				CFG_REVERSE_END_MS: cfg_q.reverse_end_ms      <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

FILE: sv/cse_step.sv
// Per-item decision logic and pulse state for the color sort eject pulser.
// Holds toggle, edge and pulse state; computes one result per item.
// Depends on cse_pkg for cfg_t, item_t, result_t and drive codes.
`default_nettype none

module cse_step (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            advance,
	input  wire cse_pkg::cfg_t   cfg,
	input  wire cse_pkg::item_t  item,
	output cse_pkg::result_t     result
);
	import cse_pkg::*;

	logic        enabled_q;
	logic        button_prev_q;
	logic        detect_prev_q;
	logic        pulse_active_q;
	logic [31:0] pulse_start_q;

	logic        rise;
	logic        en_next;
	logic        present;
	logic        hit;
	logic        start;
	logic        pulse_mid;
	logic [31:0] start_mid;
	logic [31:0] elapsed;
	logic        in_run;
	logic        in_rev;
	logic        detect_next;
	logic        pulse_next;

	// Toggle detection on a rising button edge
	assign rise    = item.button_level & ~button_prev_q;
	assign en_next = enabled_q ^ rise;

	// Match the close object against the selected hue range
	assign present = item.proximity > cfg.proximity_threshold;
	assign hit = cfg.target_is_blue
		? ((item.hue_degrees >= cfg.blue_hue_low) && (item.hue_degrees <= cfg.blue_hue_high))
		: (item.hue_degrees <= cfg.red_hue_high);

	// Start a pulse on a fresh detection with no pulse running
	assign start     = en_next & present & hit & ~pulse_active_q & ~detect_prev_q;
	assign pulse_mid = pulse_active_q | start;
	assign start_mid = start ? item.now_ms : pulse_start_q;

	// Time the pulse phases with wrapping subtraction
	assign elapsed = item.now_ms - start_mid;
	assign in_run  = elapsed < {16'd0, cfg.run_ms};
	assign in_rev  = elapsed < {16'd0, cfg.reverse_end_ms};

	assign detect_next = en_next ? (present & hit) : detect_prev_q;
	assign pulse_next  = en_next ? (pulse_mid & (in_run | in_rev)) : pulse_active_q;

	// Build the result for this item
	always_comb begin
		result.drive_issued   = en_next & pulse_mid;
		result.conveyor_drive = DRIVE_NONE;
		if (en_next && pulse_mid) begin
			result.conveyor_drive = (!in_run && in_rev) ? DRIVE_REV : DRIVE_FWD;
		end
		result.led_level      = en_next ? LED_ON : LED_OFF;
		result.rumble_request = rise ? (en_next ? RUMBLE_SINGLE : RUMBLE_DOUBLE) : RUMBLE_NONE;
		result.detection_on   = en_next;
		result.target_seen    = en_next & present & hit;
	end

	// Advance the state once per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= 1'b1;
			button_prev_q  <= 1'b0;
			detect_prev_q  <= 1'b0;
			pulse_active_q <= 1'b0;
			pulse_start_q  <= 32'd0;
		end else if (advance) begin
			enabled_q      <= en_next;
			button_prev_q  <= item.button_level;
			detect_prev_q  <= detect_next;
			pulse_active_q <= pulse_next;
			if (en_next) begin
				pulse_start_q <= start_mid;
			end
		end
	end

endmodule

`default_nettype wire
